@@ hdl/csds_pkg.sv @@
// Shared constants, types and helper functions of the circular-scan disk scheduler.
package csds_pkg;

    localparam int MAX_REQUESTS = 32;
    localparam int IDX_W        = $clog2(MAX_REQUESTS);
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int TRACK_W      = 16;
    localparam int TOTAL_W      = 24;
    localparam int SIZE_W       = 17;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_TRACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_TRACKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP    = 2'd2;

    localparam logic [SIZE_W-1:0] DISK_MIN = 17'd2;
    localparam logic [SIZE_W-1:0] DISK_MAX = 17'd65536;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_PHASE1,
        ST_EDGE,
        ST_WRAP,
        ST_PHASE2
    } csds_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic init;
        logic emit_req;
        logic emit_edge;
        logic emit_wrap;
        logic last;
    } csds_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic rem_zero;
        logic rem_one;
        logic rem2_zero;
    } csds_stat_t;

    function automatic logic [TRACK_W-1:0] abs_diff(input logic [TRACK_W-1:0] a,
                                                    input logic [TRACK_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Length of a run of ones that starts at bit 0, for an input with no ones above that run.
    function automatic logic [CNT_W-1:0] thermo_len(input logic [MAX_REQUESTS-1:0] v);
        logic [MAX_REQUESTS-1:0] nxt;
        logic [CNT_W-1:0]        len;
        nxt = v >> 1;
        len = '0;
        for (int i = 0; i < MAX_REQUESTS; i++)
        begin
            if (v[i] && !nxt[i])
            begin
                len = len | CNT_W'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

@@ hdl/csds_req_if.sv @@
// Request channel: one track request per item.
interface csds_req_if import csds_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [TRACK_W-1:0] request_track;
    logic               final_request;

    modport source (output valid, output request_track, output final_request, input ready);
    modport sink (input valid, input request_track, input final_request, output ready);
endinterface

@@ hdl/csds_res_if.sv @@
// Result channel: one visited track per item.
interface csds_res_if import csds_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [TRACK_W-1:0] visit_track;
    logic [TRACK_W-1:0] seek_move;
    logic [TOTAL_W-1:0] seek_total;
    logic               end_of_batch;
    logic               overflowed;

    modport source (output valid, output visit_track, output seek_move, output seek_total,
                    output end_of_batch, output overflowed, input ready);
    modport sink (input valid, input visit_track, input seek_move, input seek_total,
                  input end_of_batch, input overflowed, output ready);
endinterface

@@ hdl/csds_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface csds_cfg_if import csds_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/circular_scan_disk_scheduler.sv @@
// Top level of the circular-scan disk scheduler: controller, datapath and channel wiring.
//
// Requests are taken one item per cycle and inserted straight into a sorted store of
// MAX_REQUESTS entries. The item that carries final_request is loaded like the others;
// the block then stops taking requests, locates the start head in the sorted store in
// its init state and issues n + 2 results for n stored requests, one per cycle while
// the result side keeps up, with an idle step in the first-sweep state before the
// end-track visit. Requests are ready again in the cycle after the last result of the
// batch is issued, even while that result still waits to be taken. Requests beyond
// MAX_REQUESTS are dropped and every result of that batch carries overflowed. The
// configuration port is always ready and should be written only while no batch is in
// progress.
module circular_scan_disk_scheduler import csds_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    csds_req_if.sink  req,
    csds_res_if.source res,
    csds_cfg_if.sink  cfg
);

    csds_cmd_t  cmd;
    csds_stat_t stat;
    logic       in_ready;

    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    csds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_final (req.final_request),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csds_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_track  (req.request_track),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_ready (res.ready),
        .out_valid (res.valid),
        .out_track (res.visit_track),
        .out_move  (res.seek_move),
        .out_total (res.seek_total),
        .out_end   (res.end_of_batch),
        .out_ovf   (res.overflowed)
    );

`ifndef SYNTH
    // The controller never issues two commands at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.init, cmd.emit_req, cmd.emit_edge, cmd.emit_wrap}))
        else $error("overlapping datapath commands");

    // A new result is only issued when the result register is free or being emptied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_req || cmd.emit_edge || cmd.emit_wrap) |-> stat.out_free)
        else $error("result issued over a waiting result");

    // A request is only read from the store while requests of the current sweep remain.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_req |-> !stat.rem_zero)
        else $error("request read beyond the current sweep");

    // After the last result of a batch the block takes requests again.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.emit_req || cmd.emit_wrap) && cmd.last) |=> in_ready)
        else $error("requests not resumed after end of batch");
`endif

endmodule

@@ hdl/csds_datapath.sv @@
// Datapath: sorted request store, configuration registers, head and total tracking, result register.
module csds_datapath import csds_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  csds_cmd_t            cmd,
    output csds_stat_t           stat,
    input  logic [TRACK_W-1:0]   in_track,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [TRACK_W-1:0]   out_track,
    output logic [TRACK_W-1:0]   out_move,
    output logic [TOTAL_W-1:0]   out_total,
    output logic                 out_end,
    output logic                 out_ovf
);

    logic [TRACK_W-1:0] store_reg [MAX_REQUESTS];
    logic [TRACK_W-1:0] store_next [MAX_REQUESTS];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               dropped_reg, dropped_next;

    logic [TRACK_W-1:0] start_reg, start_next;
    logic [SIZE_W-1:0]  tracks_reg, tracks_next;
    logic               up_reg, up_next;

    logic [TRACK_W-1:0] head_reg, head_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [IDX_W-1:0]   idx2_reg, idx2_next;
    logic [CNT_W-1:0]   rem2_reg, rem2_next;

    logic               out_valid_reg, out_valid_next;
    logic [TRACK_W-1:0] out_track_reg, out_track_next;
    logic [TRACK_W-1:0] out_move_reg, out_move_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;
    logic               out_end_reg, out_end_next;
    logic               out_ovf_reg, out_ovf_next;

    logic [MAX_REQUESTS-1:0] greater, below, at_or_below;
    logic                    store_we;
    logic [CNT_W-1:0]        len_below, len_at_or_below;
    logic [SIZE_W-1:0]       size_c;
    logic [TRACK_W-1:0]      top;
    logic                    emit;
    logic [TRACK_W-1:0]      emit_track, emit_move;

    // Per-entry compares against the new request and against the start track.
    always_comb
    begin
        for (int i = 0; i < MAX_REQUESTS; i++)
        begin
            greater[i]     = (CNT_W'(i) < count_reg) && (store_reg[i] > in_track);
            below[i]       = (CNT_W'(i) < count_reg) && (store_reg[i] < start_reg);
            at_or_below[i] = (CNT_W'(i) < count_reg) && (store_reg[i] <= start_reg);
        end
        len_below       = thermo_len(below);
        len_at_or_below = thermo_len(at_or_below);
    end

    // Insertion keeps the store in ascending order: larger entries move up one place.
    assign store_we = cmd.load && (count_reg < CNT_W'(MAX_REQUESTS));

    always_comb
    begin
        store_next[0] = store_reg[0];
        if (greater[0] || (count_reg == '0))
        begin
            store_next[0] = in_track;
        end
        for (int i = 1; i < MAX_REQUESTS; i++)
        begin
            if (greater[i-1])
            begin
                store_next[i] = store_reg[i-1];
            end
            else if (greater[i] || (CNT_W'(i) == count_reg))
            begin
                store_next[i] = in_track;
            end
            else
            begin
                store_next[i] = store_reg[i];
            end
        end
    end

    always_comb
    begin
        size_c = tracks_reg;
        if (tracks_reg < DISK_MIN)
        begin
            size_c = DISK_MIN;
        end
        else if (tracks_reg > DISK_MAX)
        begin
            size_c = DISK_MAX;
        end
        top = TRACK_W'(size_c - SIZE_W'(1));
    end

    assign emit = cmd.emit_req || cmd.emit_edge || cmd.emit_wrap;

    always_comb
    begin
        if (cmd.emit_req)
        begin
            emit_track = store_reg[idx_reg];
            emit_move  = abs_diff(head_reg, store_reg[idx_reg]);
        end
        else if (cmd.emit_edge)
        begin
            emit_track = up_reg ? top : '0;
            emit_move  = up_reg ? abs_diff(head_reg, top) : head_reg;
        end
        else
        begin
            emit_track = up_reg ? '0 : top;
            emit_move  = top;
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        start_next   = start_reg;
        tracks_next  = tracks_reg;
        up_next      = up_reg;
        head_next    = head_reg;
        total_next   = total_reg;
        idx_next     = idx_reg;
        rem_next     = rem_reg;
        idx2_next    = idx2_reg;
        rem2_next    = rem2_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_TRACK: start_next  = cfg_data[TRACK_W-1:0];
                CFG_DISK_TRACKS: tracks_next = cfg_data;
                CFG_SWEEP_UP:    up_next     = cfg_data[0];
                default:         start_next  = start_reg;
            endcase
        end

        if (cmd.load)
        begin
            if (store_we)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end

        if (cmd.init)
        begin
            head_next  = start_reg;
            total_next = '0;
            if (up_reg)
            begin
                idx_next  = len_below[IDX_W-1:0];
                rem_next  = count_reg - len_below;
                idx2_next = '0;
                rem2_next = len_below;
            end
            else
            begin
                idx_next  = IDX_W'(len_at_or_below - CNT_W'(1));
                rem_next  = len_at_or_below;
                idx2_next = IDX_W'(count_reg - CNT_W'(1));
                rem2_next = count_reg - len_at_or_below;
            end
        end

        if (emit)
        begin
            head_next  = emit_track;
            total_next = total_reg + TOTAL_W'(emit_move);
        end

        if (cmd.emit_req)
        begin
            idx_next = up_reg ? (idx_reg + IDX_W'(1)) : (idx_reg - IDX_W'(1));
            rem_next = rem_reg - CNT_W'(1);
        end

        if (cmd.emit_wrap)
        begin
            idx_next = idx2_reg;
            rem_next = rem2_reg;
        end

        // The batch is finished once its last result is issued.
        if (emit && cmd.last)
        begin
            count_next   = '0;
            dropped_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_track_next = out_track_reg;
        out_move_next  = out_move_reg;
        out_total_next = out_total_reg;
        out_end_next   = out_end_reg;
        out_ovf_next   = out_ovf_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_track_next = emit_track;
            out_move_next  = emit_move;
            out_total_next = total_reg + TOTAL_W'(emit_move);
            out_end_next   = cmd.last;
            out_ovf_next   = dropped_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            for (int i = 0; i < MAX_REQUESTS; i++)
            begin
                store_reg[i] <= store_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            start_reg     <= '0;
            tracks_reg    <= DISK_MAX;
            up_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            start_reg     <= start_next;
            tracks_reg    <= tracks_next;
            up_reg        <= up_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg      <= head_next;
        total_reg     <= total_next;
        idx_reg       <= idx_next;
        rem_reg       <= rem_next;
        idx2_reg      <= idx2_next;
        rem2_reg      <= rem2_next;
        out_track_reg <= out_track_next;
        out_move_reg  <= out_move_next;
        out_total_reg <= out_total_next;
        out_end_reg   <= out_end_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.rem_zero  = (rem_reg == '0);
    assign stat.rem_one   = (rem_reg == CNT_W'(1));
    assign stat.rem2_zero = (rem2_reg == '0);

    assign out_valid = out_valid_reg;
    assign out_track = out_track_reg;
    assign out_move  = out_move_reg;
    assign out_total = out_total_reg;
    assign out_end   = out_end_reg;
    assign out_ovf   = out_ovf_reg;

endmodule

@@ hdl/csds_ctrl.sv @@
// Controller: sequences loading, the first sweep, the end-track and wrap visits and the second sweep.
module csds_ctrl import csds_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_final,
    output logic       in_ready,
    input  csds_stat_t stat,
    output csds_cmd_t  cmd
);

    csds_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && in_final)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:   state_next = ST_PHASE1;
            ST_PHASE1:
            begin
                if (stat.rem_zero)
                begin
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.rem2_zero ? ST_LOAD : ST_PHASE2;
                end
            end
            ST_PHASE2:
            begin
                if (stat.out_free && stat.rem_one)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:   state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_INIT:   cmd.init = 1'b1;
            ST_PHASE1: cmd.emit_req = !stat.rem_zero && stat.out_free;
            ST_EDGE:   cmd.emit_edge = stat.out_free;
            ST_WRAP:
            begin
                cmd.emit_wrap = stat.out_free;
                cmd.last      = stat.rem2_zero;
            end
            ST_PHASE2:
            begin
                cmd.emit_req = stat.out_free;
                cmd.last     = stat.rem_one;
            end
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench of the circular-scan disk scheduler: directed table, then random batches.
module tb_top;
    import csds_pkg::*;

    localparam int RANDOM_ITEMS  = 230;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int SQUEEZE_BATCH = 8;
    localparam int MAX_PRINTS    = 40;
    localparam int TABLE_ROWS    = 32;

    typedef struct packed {
        logic [TRACK_W-1:0] visit_track;
        logic [TRACK_W-1:0] seek_move;
        logic [TOTAL_W-1:0] seek_total;
        logic               end_of_batch;
        logic               overflowed;
    } visit_t;

    typedef enum bit {ROW_WRITE, ROW_REQUEST} row_kind_t;

    // On request rows reg_idx is unused and value carries the track.
    typedef struct {
        row_kind_t           kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [SIZE_W-1:0]   value;
        bit                  fin;
        bit                  typed;
        logic [TRACK_W-1:0]  exp_track;
        logic [TOTAL_W-1:0]  exp_total;
        bit                  exp_ovf;
    } stim_row_t;

    stim_row_t directed_rows [TABLE_ROWS] = '{
        '{ROW_REQUEST, CFG_START_TRACK, 17'd0,      1'b1, 1'b1, 16'd0,     24'd131070, 1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd65535,  1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd100,    1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd100,    1'b1, 1'b1, 16'd0,     24'd131070, 1'b0},
        '{ROW_WRITE,   CFG_START_TRACK, 17'd1000,   1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_WRITE,   CFG_SWEEP_UP,    17'd0,      1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_WRITE,   CFG_DISK_TRACKS, 17'd1,      1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd5,      1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd2000,   1'b1, 1'b1, 16'd2000,  24'd3000,   1'b0},
        '{ROW_WRITE,   CFG_DISK_TRACKS, 17'h1FFFF,  1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_WRITE,   CFG_START_TRACK, 17'd65535,  1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd65535,  1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd0,      1'b1, 1'b1, 16'd65535, 24'd131070, 1'b0},
        '{ROW_WRITE,   CFG_SWEEP_UP,    17'd1,      1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd10,     1'b1, 1'b1, 16'd10,    24'd65545,  1'b0},
        '{ROW_WRITE,   CFG_DISK_TRACKS, 17'd100,    1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_WRITE,   CFG_START_TRACK, 17'd500,    1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd700,    1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd50,     1'b1, 1'b1, 16'd50,    24'd950,    1'b0},
        '{ROW_WRITE,   CFG_DISK_TRACKS, 17'd2,      1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_WRITE,   CFG_START_TRACK, 17'd0,      1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_WRITE,   CFG_SWEEP_UP,    17'd0,      1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd0,      1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd1,      1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd0,      1'b1, 1'b1, 16'd1,     24'd1,      1'b0},
        '{ROW_WRITE,   CFG_DISK_TRACKS, 17'd65536,  1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_WRITE,   CFG_SWEEP_UP,    17'd1,      1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_WRITE,   CFG_START_TRACK, 17'd32768,  1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd32768,  1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd32767,  1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd40000,  1'b0, 1'b0, 16'd0,     24'd0,      1'b0},
        '{ROW_REQUEST, CFG_START_TRACK, 17'd12345,  1'b1, 1'b0, 16'd0,     24'd0,      1'b0}
    };

    logic clk;
    logic rst_n;

    csds_req_if req ();
    csds_res_if res ();
    csds_cfg_if cfg ();

    circular_scan_disk_scheduler i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res),
        .cfg   (cfg)
    );

    // Shadow of the scheduler: pending batch, registers and the visits still to come.
    logic [TRACK_W-1:0] held_tracks[$];
    bit                 lost_request;
    logic [TRACK_W-1:0] head_start;
    logic [SIZE_W-1:0]  disk_size;
    bit                 sweep_high_first;
    logic [TOTAL_W-1:0] batch_seek;
    visit_t             awaited_visits[$];

    int  requests_sent;
    int  batches_served;
    int  register_writes;
    int  visits_checked;
    int  mismatches;
    bit  squeeze_armed;

    function automatic logic [TRACK_W-1:0] track_gap(input logic [TRACK_W-1:0] a,
                                                     input logic [TRACK_W-1:0] b);
        if (a > b)
            return a - b;
        return b - a;
    endfunction

    function automatic void log_visit(input logic [TRACK_W-1:0] track,
                                      input logic [TRACK_W-1:0] move);
        visit_t v;
        batch_seek     = batch_seek + TOTAL_W'(move);
        v.visit_track  = track;
        v.seek_move    = move;
        v.seek_total   = batch_seek;
        v.end_of_batch = 1'b0;
        v.overflowed   = lost_request;
        awaited_visits.push_back(v);
    endfunction

    function automatic void plan_service(input logic [TRACK_W-1:0] track, input bit fin);
        logic [TRACK_W-1:0] order[$];
        logic [TRACK_W-1:0] key;
        logic [TRACK_W-1:0] top;
        logic [TRACK_W-1:0] pos;
        logic [SIZE_W-1:0]  size;
        visit_t             tail;
        int                 j;
        if (held_tracks.size() < MAX_REQUESTS)
            held_tracks.push_back(track);
        else
            lost_request = 1'b1;
        if (!fin)
            return;

        foreach (held_tracks[i])
        begin
            key = held_tracks[i];
            j = order.size();
            while (j > 0 && order[j-1] > key)
                j--;
            order.insert(j, key);
        end

        size = disk_size;
        if (size < DISK_MIN)
            size = DISK_MIN;
        if (size > DISK_MAX)
            size = DISK_MAX;
        top = TRACK_W'(size - 1);
        pos = head_start;
        batch_seek = '0;

        if (sweep_high_first)
        begin
            foreach (order[i])
            begin
                if (order[i] >= head_start)
                begin
                    log_visit(order[i], track_gap(pos, order[i]));
                    pos = order[i];
                end
            end
            log_visit(top, track_gap(pos, top));
            // The jump back to track 0 is booked as a full sweep of the disk.
            log_visit('0, top);
            pos = '0;
            foreach (order[i])
            begin
                if (order[i] < head_start)
                begin
                    log_visit(order[i], track_gap(pos, order[i]));
                    pos = order[i];
                end
            end
        end
        else
        begin
            for (int i = order.size() - 1; i >= 0; i--)
            begin
                if (order[i] <= head_start)
                begin
                    log_visit(order[i], track_gap(pos, order[i]));
                    pos = order[i];
                end
            end
            log_visit('0, pos);
            log_visit(top, top);
            pos = top;
            for (int i = order.size() - 1; i >= 0; i--)
            begin
                if (order[i] > head_start)
                begin
                    log_visit(order[i], track_gap(pos, order[i]));
                    pos = order[i];
                end
            end
        end

        tail = awaited_visits.pop_back();
        tail.end_of_batch = 1'b1;
        awaited_visits.push_back(tail);
        held_tracks.delete();
        lost_request = 1'b0;
        batches_served++;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TRACK_W-1:0] pick_track(input logic [TRACK_W-1:0] prev);
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1: return head_start;
            2: return prev;
            3: return head_start + TRACK_W'($urandom_range(0, 6)) - TRACK_W'(3);
            4: return TRACK_W'($urandom_range(0, 300));
            default: return TRACK_W'($urandom);
        endcase
    endfunction

    task automatic note_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("Mismatch at visit %0d, %s: got %0d, expected %0d",
                     visits_checked, field, got, want);
    endtask

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic offer_request(input logic [TRACK_W-1:0] track, input bit fin, input int gap);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid         <= 1'b1;
        req.request_track <= track;
        req.final_request <= fin;
        do
            @(posedge clk);
        while (!req.ready);
        plan_service(track, fin);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SIZE_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            CFG_START_TRACK: head_start = value[TRACK_W-1:0];
            CFG_DISK_TRACKS: disk_size = value;
            CFG_SWEEP_UP:    sweep_high_first = value[0];
            default: ;
        endcase
        register_writes++;
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle_block();
        req.valid <= 1'b0;
        while (awaited_visits.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic reshape_disk();
        int unsigned       which;
        logic [SIZE_W-1:0] value;
        which = $urandom_range(1, 7);
        settle_block();
        if (which[0])
        begin
            case ($urandom_range(0, 4))
                0: value = '0;
                1: value = {1'($urandom_range(0, 1)), 16'hFFFF};
                default: value = SIZE_W'($urandom_range(0, 131071));
            endcase
            write_register(CFG_START_TRACK, value);
        end
        if (which[1])
        begin
            case ($urandom_range(0, 7))
                0: value = DISK_MIN;
                1: value = DISK_MAX;
                2: value = SIZE_W'($urandom_range(0, 1));
                3: value = SIZE_W'($urandom_range(65537, 131071));
                4, 5: value = SIZE_W'($urandom_range(2, 400));
                default: value = SIZE_W'($urandom_range(2, 65536));
            endcase
            write_register(CFG_DISK_TRACKS, value);
        end
        if (which[2])
        begin
            if ($urandom_range(0, 3) == 0)
                value = SIZE_W'($urandom_range(0, 131071));
            else
                value = SIZE_W'($urandom_range(0, 1));
            write_register(CFG_SWEEP_UP, value);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin : stimulus
        stim_row_t          row;
        visit_t             tail;
        int                 random_sent;
        int                 batch_no;
        int                 batch_len;
        int unsigned        r;
        bit                 burst;
        logic [TRACK_W-1:0] prev;

        rst_n             = 1'b0;
        req.valid         = 1'b0;
        req.request_track = '0;
        req.final_request = 1'b0;
        cfg.valid         = 1'b0;
        cfg.index         = CFG_START_TRACK;
        cfg.data          = '0;
        head_start        = '0;
        disk_size         = DISK_MAX;
        sweep_high_first  = 1'b1;
        lost_request      = 1'b0;
        squeeze_armed     = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[n])
        begin
            row = directed_rows[n];
            if (row.kind == ROW_WRITE)
            begin
                settle_block();
                write_register(row.reg_idx, row.value);
            end
            else
            begin
                offer_request(row.value[TRACK_W-1:0], row.fin, idle_cycles());
                if (row.typed)
                begin
                    // The closing visit of this batch is known by hand.
                    tail = awaited_visits.pop_back();
                    tail.visit_track = row.exp_track;
                    tail.seek_total  = row.exp_total;
                    tail.overflowed  = row.exp_ovf;
                    awaited_visits.push_back(tail);
                end
            end
        end

        random_sent = 0;
        batch_no    = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (batch_no != SQUEEZE_BATCH + 1 && $urandom_range(0, 2) == 0)
                reshape_disk();
            burst = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            if (batch_no == SQUEEZE_BATCH)
            begin
                // A full store plus one, sent back to back while the result side is held off.
                burst         = 1'b1;
                batch_len     = MAX_REQUESTS + 1;
                squeeze_armed = 1'b1;
            end
            else if (r < 8)
                batch_len = $urandom_range(1, 8);
            else if (r < 9)
                batch_len = $urandom_range(9, 20);
            else
                batch_len = MAX_REQUESTS - 1 + $urandom_range(0, 9);
            prev = head_start;
            for (int k = 0; k < batch_len; k++)
            begin
                prev = pick_track(prev);
                offer_request(prev, k == batch_len - 1, burst ? 0 : idle_cycles());
            end
            random_sent += batch_len;
            batch_no++;
        end

        settle_block();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Run covered %0d requests in %0d batches and %0d register writes,",
                 requests_sent, batches_served, register_writes);
        $display("with %0d visits compared field by field.", visits_checked);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Result side: choppy and steady stretches, plus one long hold-off when asked.
    initial
    begin : result_sink
        int hold_left;
        int gap_left;
        int phase_left;
        bit choppy;
        res.ready  = 1'b0;
        hold_left  = 0;
        gap_left   = 0;
        phase_left = 0;
        choppy     = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze_armed)
            begin
                squeeze_armed = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (!rst_n)
                res.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                res.ready <= 1'b0;
            end
            else
            begin
                res.ready <= 1'b1;
                if (phase_left == 0)
                begin
                    choppy     = $urandom_range(0, 1);
                    phase_left = $urandom_range(20, 80);
                end
                else
                    phase_left--;
                if (choppy && $urandom_range(0, 2) == 0)
                    gap_left = idle_cycles();
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        visit_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (awaited_visits.size() == 0)
                note_mismatch("visit with none awaited, track", res.visit_track, 0);
            else
            begin
                want = awaited_visits.pop_front();
                if (res.visit_track !== want.visit_track)
                    note_mismatch("visit_track", res.visit_track, want.visit_track);
                if (res.seek_move !== want.seek_move)
                    note_mismatch("seek_move", res.seek_move, want.seek_move);
                if (res.seek_total !== want.seek_total)
                    note_mismatch("seek_total", res.seek_total, want.seek_total);
                if (res.end_of_batch !== want.end_of_batch)
                    note_mismatch("end_of_batch", res.end_of_batch, want.end_of_batch);
                if (res.overflowed !== want.overflowed)
                    note_mismatch("overflowed", res.overflowed, want.overflowed);
            end
            visits_checked++;
        end
    end

    initial
    begin : stall_watch
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req.valid && req.ready) || (res.valid && res.ready)
                || (cfg.valid && cfg.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

endmodule
